// File: rtl/chte_pkg.sv
// Shared types and constants of the chained hash table engine.
package chte_pkg;

    localparam int BUCKET_SLOTS = 1024;
    localparam int POOL_ENTRIES = 256;
    localparam int BKT_AW       = $clog2(BUCKET_SLOTS);
    localparam int ENT_AW       = $clog2(POOL_ENTRIES);
    localparam int LINK_W       = ENT_AW + 1;
    localparam int STEP_W       = ENT_AW + 1;

    localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(POOL_ENTRIES);

    localparam logic [31:0] HASH_MUL = 32'd278;
    localparam logic [31:0] HASH_ADD = 32'd12345;

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_SET    = 2'd2,
        CMD_DELETE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_PRESENT  = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [0:0] {
        REG_BUCKET_COUNT = 1'd0,
        REG_MAX_ENTRIES  = 1'd1
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_HASH,
        S_MOD,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_ENT_WAIT,
        S_ENT_CHECK,
        S_DEL_LINK,
        S_ALLOC_WAIT,
        S_ALLOC,
        S_OUT
    } state_t;

    // Request from the control FSM to the bucket-modulo unit
    typedef struct packed {
        logic        start;
        logic [31:0] hash;
        logic [BKT_AW:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic             done;
        logic [BKT_AW-1:0] bucket;
    } mod_rsp_t;

endpackage

// File: rtl/chte_mod_unit.sv
// Restoring remainder unit: hash mod bucket count, one bit per cycle.
module chte_mod_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  chte_pkg::mod_req_t  req,
    output chte_pkg::mod_rsp_t  rsp
);
    import chte_pkg::*;

    logic [31:0]     dividend_reg, dividend_next;
    logic [BKT_AW:0] rem_reg, rem_next;
    logic [BKT_AW:0] div_reg, div_next;
    logic [5:0]      cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [BKT_AW+1:0] trial;

    always_comb begin
        dividend_next = dividend_reg;
        rem_next      = rem_reg;
        div_next      = div_reg;
        cnt_next      = cnt_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        trial         = {rem_reg, dividend_reg[31]};
        if (req.start) begin
            dividend_next = req.hash;
            div_next      = req.divisor;
            rem_next      = '0;
            cnt_next      = 6'd32;
            busy_next     = 1'b1;
        end else if (busy_reg) begin
            dividend_next = {dividend_reg[30:0], 1'b0};
            if (trial >= {1'b0, div_reg}) begin
                rem_next = (BKT_AW+1)'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[BKT_AW:0];
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        div_reg      <= div_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.bucket = rem_reg[BKT_AW-1:0];

endmodule

// File: rtl/chte_ram.sv
// Generic single-port-write, one-read synchronous RAM.
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/chained_hash_table_engine.sv
// Top level of the chained hash table engine: control FSM and table memories.
//
// One command per transfer on s_axis; one result per command on m_axis.
// After reset the block sweeps the 1024 bucket heads to null,
// holding s_axis_tready low; configuration writes are accepted throughout.
// Free-list links need no sweep: a fill count hands out never-used entries
// in order before the recycled free list is consulted. A command runs the
// hash multiply, a 32-step bit-serial remainder by the bucket count made
// odd, then one bucket-head read and a key/link/value read per chain entry,
// each via a synchronous RAM. A set writes during the key compare; a delete
// adds state S_DEL_LINK, an add S_ALLOC (after S_ALLOC_WAIT if recycled).
// Commands are handled one at a time; the result register frees the block
// to take the next command while the result waits on m_axis, and a finished
// command waits for that register to empty.
module chained_hash_table_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // cmd[1:0], key[33:2], value_in[65:34], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // status[1:0], value_out[33:2], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import chte_pkg::*;

    // configuration
    logic [9:0] bucket_count_reg;
    logic [8:0] max_entries_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= 10'd1023;
            max_entries_reg  <= 9'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_BUCKET_COUNT: bucket_count_reg <= cfg_data;
                REG_MAX_ENTRIES:  max_entries_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // command registers
    state_t state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [31:0]      key_reg, key_next;
    logic [31:0]      val_reg, val_next;
    logic [31:0]      hash_reg, hash_next;
    logic [BKT_AW-1:0] bkt_reg, bkt_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [STEP_W-1:0] steps_reg, steps_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] fill_reg, fill_next;
    logic [8:0]        live_reg, live_next;
    logic [BKT_AW:0]   clr_reg, clr_next;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       vout_reg, vout_next;
    logic              mvalid_reg, mvalid_next;
    logic [1:0]        m_status_reg, m_status_next;
    logic [31:0]       m_vout_reg, m_vout_next;
    logic              alloc_recycled_reg;

    // memories
    logic              head_we;
    logic [BKT_AW-1:0] head_waddr, head_raddr;
    logic [LINK_W-1:0] head_wdata, head_rdata;
    logic              key_we, valm_we, link_we;
    logic [ENT_AW-1:0] key_waddr, valm_waddr, link_waddr, ent_raddr;
    logic [31:0]       key_wdata, valm_wdata, key_rdata, valm_rdata;
    logic [LINK_W-1:0] link_wdata, link_rdata;

    chte_ram #(.WIDTH(LINK_W), .DEPTH(BUCKET_SLOTS)) u_heads (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata));
    chte_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_keys (
        .aclk(aclk), .we(key_we), .waddr(key_waddr), .wdata(key_wdata),
        .raddr(ent_raddr), .rdata(key_rdata));
    chte_ram #(.WIDTH(32), .DEPTH(POOL_ENTRIES)) u_vals (
        .aclk(aclk), .we(valm_we), .waddr(valm_waddr), .wdata(valm_wdata),
        .raddr(ent_raddr), .rdata(valm_rdata));
    chte_ram #(.WIDTH(LINK_W), .DEPTH(POOL_ENTRIES)) u_links (
        .aclk(aclk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(ent_raddr), .rdata(link_rdata));

    // remainder unit
    mod_req_t mreq;
    mod_rsp_t mrsp;
    logic [BKT_AW:0] divisor;
    logic [9:0]      bc_odd;

    assign bc_odd  = bucket_count_reg | 10'd1;
    assign divisor = ({1'b0, bc_odd} > 11'(BUCKET_SLOTS)) ?
                     (BKT_AW+1)'(BUCKET_SLOTS) : (BKT_AW+1)'(bc_odd);

    chte_mod_unit u_mod (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));

    logic s_fire, m_fire, full;
    assign s_fire = s_axis_tvalid && s_axis_tready;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    // table full: limit reached, or no never-used entry and empty free list
    assign full = ((max_entries_reg != 9'd0) && (live_reg >= max_entries_reg)) ||
                  ((fill_reg == NIL_LINK) && (free_head_reg == NIL_LINK));

    assign s_axis_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        val_next       = val_reg;
        hash_next      = hash_reg;
        bkt_next       = bkt_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        steps_next     = steps_reg;
        free_head_next = free_head_reg;
        fill_next      = fill_reg;
        live_next      = live_reg;
        clr_next       = clr_reg;
        status_next    = status_reg;
        vout_next      = vout_reg;
        mvalid_next    = mvalid_reg && !m_fire;
        m_status_next  = m_status_reg;
        m_vout_next    = m_vout_reg;
        mreq.start     = 1'b0;
        mreq.hash      = hash_reg;
        mreq.divisor   = divisor;
        head_we        = 1'b0;
        head_waddr     = bkt_reg;
        head_wdata     = NIL_LINK;
        head_raddr     = bkt_reg;
        key_we         = 1'b0;
        key_waddr      = cur_reg[ENT_AW-1:0];
        key_wdata      = key_reg;
        valm_we        = 1'b0;
        valm_waddr     = cur_reg[ENT_AW-1:0];
        valm_wdata     = val_reg;
        link_we        = 1'b0;
        link_waddr     = cur_reg[ENT_AW-1:0];
        link_wdata     = NIL_LINK;
        ent_raddr      = cur_reg[ENT_AW-1:0];
        case (state_reg)
            S_CLEAR: begin
                head_we    = 1'b1;
                head_waddr = clr_reg[BKT_AW-1:0];
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == (BKT_AW+1)'(BUCKET_SLOTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_fire) begin
                    cmd_next   = cmd_t'(s_axis_tdata[1:0]);
                    key_next   = s_axis_tdata[33:2];
                    val_next   = s_axis_tdata[65:34];
                    state_next = S_HASH;
                end
            end
            S_HASH: begin
                hash_next  = key_reg * HASH_MUL + HASH_ADD;
                state_next = S_MOD;
                status_next = ST_OK;
                vout_next   = '0;
            end
            S_MOD: begin
                mreq.start = (steps_reg != '1);
                steps_next = '1;
                if (mrsp.done) begin
                    bkt_next   = mrsp.bucket;
                    state_next = S_HEAD_RD;
                end
            end
            S_HEAD_RD: begin
                state_next = S_HEAD_WAIT;
            end
            S_HEAD_WAIT: begin
                cur_next   = head_rdata;
                prev_next  = NIL_LINK;
                steps_next = '0;
                state_next = S_ENT_WAIT;
            end
            S_ENT_WAIT: begin
                if (cur_reg == NIL_LINK || steps_reg == STEP_W'(POOL_ENTRIES)) begin
                    // key absent
                    cur_next = NIL_LINK;
                    case (cmd_reg)
                        CMD_LOOKUP, CMD_DELETE: begin
                            status_next = ST_NOTFOUND;
                            state_next  = S_OUT;
                        end
                        default: begin
                            if (full) begin
                                status_next = ST_FULL;
                                state_next  = S_OUT;
                            end else if (fill_reg != NIL_LINK) begin
                                cur_next   = fill_reg;
                                fill_next  = fill_reg + 1'b1;
                                state_next = S_ALLOC;
                            end else begin
                                cur_next   = free_head_reg;
                                state_next = S_ALLOC_WAIT;
                            end
                        end
                    endcase
                end else begin
                    state_next = S_ENT_CHECK;
                end
            end
            S_ENT_CHECK: begin
                if (key_rdata == key_reg) begin
                    case (cmd_reg)
                        CMD_LOOKUP: begin
                            vout_next  = valm_rdata;
                            state_next = S_OUT;
                        end
                        CMD_ADD: begin
                            status_next = ST_PRESENT;
                            state_next  = S_OUT;
                        end
                        CMD_SET: begin
                            valm_we    = 1'b1;
                            state_next = S_OUT;
                        end
                        default: begin
                            // unlink from chain: predecessor or head takes our link
                            if (prev_reg == NIL_LINK) begin
                                head_we    = 1'b1;
                                head_wdata = link_rdata;
                            end else begin
                                link_we    = 1'b1;
                                link_waddr = prev_reg[ENT_AW-1:0];
                                link_wdata = link_rdata;
                            end
                            state_next = S_DEL_LINK;
                        end
                    endcase
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = link_rdata;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_ENT_WAIT;
                end
            end
            S_DEL_LINK: begin
                link_we        = 1'b1;
                link_wdata     = free_head_reg;
                free_head_next = cur_reg;
                if (live_reg != 9'd0) begin
                    live_next = live_reg - 9'd1;
                end
                state_next = S_OUT;
            end
            S_ALLOC_WAIT: begin
                state_next = S_ALLOC;
                // recycled entry: its link read is in flight
            end
            S_ALLOC: begin
                if (alloc_recycled_reg) begin
                    free_head_next = link_rdata;
                end
                key_we     = 1'b1;
                valm_we    = 1'b1;
                link_we    = 1'b1;
                link_wdata = head_rdata;
                head_we    = 1'b1;
                head_wdata = cur_reg;
                live_next  = live_reg + 9'd1;
                state_next = S_OUT;
            end
            S_OUT: begin
                // wait here while the previous result is still held
                if (!mvalid_reg || m_fire) begin
                    mvalid_next   = 1'b1;
                    m_status_next = status_reg;
                    m_vout_next   = vout_reg;
                    steps_next    = '0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // head_rdata stays valid through the chain walk: head address holds bkt_reg
    // and an add makes no head write before S_ALLOC.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            free_head_reg <= NIL_LINK;
            fill_reg      <= '0;
            live_reg      <= '0;
            mvalid_reg    <= 1'b0;
            steps_reg     <= '0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            free_head_reg <= free_head_next;
            fill_reg      <= fill_next;
            live_reg      <= live_next;
            mvalid_reg    <= mvalid_next;
            steps_reg     <= steps_next;
        end
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        val_reg      <= val_next;
        hash_reg     <= hash_next;
        bkt_reg      <= bkt_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        status_reg   <= status_next;
        vout_reg     <= vout_next;
        m_status_reg <= m_status_next;
        m_vout_reg   <= m_vout_next;
        alloc_recycled_reg <= (state_reg == S_ALLOC_WAIT);
    end

    assign m_axis_tvalid = mvalid_reg;
    assign m_axis_tdata  = {6'd0, m_vout_reg, m_status_reg};

`ifndef SYNTHESIS
    // never more live entries than the pool holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        live_reg <= 9'(POOL_ENTRIES))
        else $error("live count exceeds pool");

    // a stalled result holds its data until taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // a new entry is only written when the table is not full
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ALLOC) |-> (live_reg < 9'(POOL_ENTRIES)))
        else $error("allocation on a full pool");

    // remainder unit answers only while the FSM waits for it
    assert property (@(posedge aclk) disable iff (!aresetn)
        mrsp.done |-> (state_reg == S_MOD))
        else $error("stray remainder result");
`endif

endmodule
